### hdl/bnr_pkg.sv
// ----------------------------------------------------------------------------
// bnr_pkg
// shared widths, register indexes and constants of the notch-reject mask
// ----------------------------------------------------------------------------
package bnr_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CUTOFF_W   = 16;
	localparam int NOTCH_W    = 11;
	localparam int ORDER_W    = 4;
	localparam int W2_W       = 32;   // cutoff squared, Q.16
	localparam int P_W        = 32;   // t and t^n, Q16.16
	localparam int FACTOR_W   = 17;   // gain factor, Q1.16
	localparam int RECIP_W    = 33;   // 2^32 dividend and 65536+p divisor

	localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_X = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_Y = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ORDER   = 3'd4;

	localparam logic [P_W-1:0]     P_CAP      = 32'hFFFF_FFFF;
	localparam logic [RECIP_W-1:0] ONE_Q16    = 33'h0_0001_0000;
	localparam logic [RECIP_W-1:0] RECIP_NUM  = 33'h1_0000_0000;

	localparam logic [CUTOFF_W-1:0] CUTOFF_RST  = 16'd512;
	localparam logic [NOTCH_W-1:0]  NOTCH_X_RST = 11'd32;
	localparam logic [NOTCH_W-1:0]  NOTCH_Y_RST = 11'd16;
	localparam logic [ORDER_W-1:0]  ORDER_RST   = 4'd1;

endpackage

### hdl/bnr_udiv.sv
// ----------------------------------------------------------------------------
// bnr_udiv
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bnr_udiv
	import bnr_pkg::*;
#(
	parameter int NUM_W = 32,
	parameter int DEN_W = 24,
	parameter int QUO_W = 32,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo,
	output logic [SB_W-1:0]  sb_out
);

	logic             vld_s [QUO_W];
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [NUM_W-1:0] num_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [SB_W-1:0]  sb_s  [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int J = QUO_W - 1 - i;
		logic             vld_p;
		logic [DEN_W-1:0] rem_p;
		logic [NUM_W-1:0] num_p;
		logic [DEN_W-1:0] den_p;
		logic [QUO_W-1:0] quo_p;
		logic [SB_W-1:0]  sb_p;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (i == 0) begin : g_first
			// upper quotient bits are known zero, so the leading part is a remainder
			assign vld_p = in_valid;
			assign rem_p = DEN_W'(num >> QUO_W);
			assign num_p = num;
			assign den_p = den;
			assign quo_p = '0;
			assign sb_p  = sb_in;
		end else begin : g_next
			assign vld_p = vld_s[i-1];
			assign rem_p = rem_s[i-1];
			assign num_p = num_s[i-1];
			assign den_p = den_s[i-1];
			assign quo_p = quo_s[i-1];
			assign sb_p  = sb_s[i-1];
		end

		always_comb begin
			trial = {rem_p, num_p[J]};
			diff  = trial - {1'b0, den_p};
			ge    = (trial >= {1'b0, den_p});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_s[i] <= num_p;
			den_s[i] <= den_p;
			quo_s[i] <= quo_p | (QUO_W'(ge) << J);
			sb_s[i]  <= sb_p;
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign sb_out    = sb_s[QUO_W-1];

endmodule

### hdl/bnr_power.sv
// ----------------------------------------------------------------------------
// bnr_power
// saturating t^n chain, one 32x32 multiply per stage
// ----------------------------------------------------------------------------
module bnr_power
	import bnr_pkg::*;
#(
	parameter int MAX_ORDER = 8,
	parameter int N_W       = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [N_W-1:0] n_eff,
	input  logic           in_valid,
	input  logic [P_W-1:0] t_in,
	input  logic           zero_in,
	output logic           out_valid,
	output logic [P_W-1:0] p_out,
	output logic           zero_out
);

	localparam int STAGES = MAX_ORDER - 1;

	if (STAGES == 0) begin : g_none
		assign out_valid = in_valid;
		assign p_out     = t_in;
		assign zero_out  = zero_in;
	end else begin : g_chain
		logic           vld_s  [STAGES];
		logic [P_W-1:0] p_s    [STAGES];
		logic [P_W-1:0] t_s    [STAGES];
		logic           sat_s  [STAGES];
		logic           zero_s [STAGES];

		for (genvar k = 1; k <= STAGES; k++) begin : g_stage
			logic               vld_p, sat_p, zero_p;
			logic [P_W-1:0]     p_p, t_p, p_n;
			logic               sat_n;
			logic [2*P_W-1:0]   prod;
			logic [2*P_W-17:0]  shr;
			logic               active;

			if (k == 1) begin : g_first
				assign vld_p  = in_valid;
				assign p_p    = t_in;
				assign t_p    = t_in;
				assign sat_p  = 1'b0;
				assign zero_p = zero_in;
			end else begin : g_next
				assign vld_p  = vld_s[k-2];
				assign p_p    = p_s[k-2];
				assign t_p    = t_s[k-2];
				assign sat_p  = sat_s[k-2];
				assign zero_p = zero_s[k-2];
			end

			always_comb begin
				prod   = (2*P_W)'(p_p) * (2*P_W)'(t_p);
				shr    = prod[2*P_W-1:16];
				active = (int'(n_eff) > k) && !sat_p;
				p_n    = p_p;
				sat_n  = sat_p;
				if (active) begin
					// once capped the value stays at the cap
					if (shr >= (2*P_W-16)'(P_CAP)) begin
						p_n   = P_CAP;
						sat_n = 1'b1;
					end else begin
						p_n = shr[P_W-1:0];
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k-1] <= 1'b0;
				end else begin
					vld_s[k-1] <= vld_p;
				end
			end

			always_ff @(posedge clk) begin
				p_s[k-1]    <= p_n;
				t_s[k-1]    <= t_p;
				sat_s[k-1]  <= sat_n;
				zero_s[k-1] <= zero_p;
			end
		end

		assign out_valid = vld_s[STAGES-1];
		assign p_out     = p_s[STAGES-1];
		assign zero_out  = zero_s[STAGES-1];
	end

endmodule

### hdl/bnr_factor.sv
// ----------------------------------------------------------------------------
// bnr_factor
// one high-pass factor 1/(1+t^n) about an offset point
// ----------------------------------------------------------------------------
module bnr_factor
	import bnr_pkg::*;
#(
	parameter int COORD_BITS = 11,
	parameter int MAX_ORDER  = 8,
	parameter int N_W        = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [W2_W-1:0]            w2,
	input  logic [N_W-1:0]             n_eff,
	input  logic                       in_valid,
	input  logic signed [COORD_BITS:0] du,
	input  logic signed [COORD_BITS:0] dv,
	output logic                       out_valid,
	output logic [FACTOR_W-1:0]        factor,
	output logic                       zero
);

	localparam int A_W = COORD_BITS + 1;
	localparam int D_W = 2 * A_W;

	logic           vld_s1, vld_s2;
	logic [A_W-1:0] au_s1, av_s1;
	logic [D_W-1:0] d2_s2;
	logic           zero_s2;
	logic [D_W-1:0] d2_n;

	always_comb begin
		d2_n = D_W'(au_s1) * D_W'(au_s1) + D_W'(av_s1) * D_W'(av_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		au_s1   <= du[COORD_BITS] ? A_W'(-du) : A_W'(du);
		av_s1   <= dv[COORD_BITS] ? A_W'(-dv) : A_W'(dv);
		d2_s2   <= d2_n;
		zero_s2 <= (d2_n == '0);
	end

	logic           t_vld, t_zero;
	logic [P_W-1:0] t_val;

	bnr_udiv #(.NUM_W(W2_W), .DEN_W(D_W), .QUO_W(P_W), .SB_W(1)) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.num      (w2),
		.den      (d2_s2),
		.sb_in    (zero_s2),
		.out_valid(t_vld),
		.quo      (t_val),
		.sb_out   (t_zero)
	);

	logic           p_vld, p_zero;
	logic [P_W-1:0] p_val;

	bnr_power #(.MAX_ORDER(MAX_ORDER), .N_W(N_W)) u_power (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_eff    (n_eff),
		.in_valid (t_vld),
		.t_in     (t_val),
		.zero_in  (t_zero),
		.out_valid(p_vld),
		.p_out    (p_val),
		.zero_out (p_zero)
	);

	logic                r_vld, r_zero;
	logic [FACTOR_W-1:0] r_quo;

	bnr_udiv #(.NUM_W(RECIP_W), .DEN_W(RECIP_W), .QUO_W(FACTOR_W), .SB_W(1)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (p_vld),
		.num      (RECIP_NUM),
		.den      (RECIP_W'(p_val) + ONE_Q16),
		.sb_in    (p_zero),
		.out_valid(r_vld),
		.quo      (r_quo),
		.sb_out   (r_zero)
	);

	assign out_valid = r_vld;
	assign zero      = r_zero;
	assign factor    = r_zero ? '0 : r_quo;

endmodule

### hdl/butterworth_notch_reject_mask.sv
// ----------------------------------------------------------------------------
// butterworth_notch_reject_mask
// butterworth high-pass / notch-reject gain per frequency coordinate
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, busy is never raised
// the pipeline length is set by two bit-serial divider pipelines (32 and 17 stages)
// plus one multiply stage per extra order of the power chain
// reset clears all valid bits and loads the register defaults; the
// receiver cannot stall, so done follows start at a fixed distance
module butterworth_notch_reject_mask
	import bnr_pkg::*;
#(
	parameter int COORD_BITS = 11,
	parameter int MAX_ORDER  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] u_coord,
	input  logic signed [COORD_BITS-1:0] v_coord,
	// result side
	output logic                         done,
	output logic [FACTOR_W-1:0]          gain,
	output logic                         at_centre
);

	localparam int N_W   = $clog2(MAX_ORDER + 1);
	localparam int EXT_W = NOTCH_W + COORD_BITS;

	// configuration registers
	logic                mode_q;
	logic [CUTOFF_W-1:0] cutoff_q;
	logic [NOTCH_W-1:0]  notch_x_q, notch_y_q;
	logic [ORDER_W-1:0]  order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			cutoff_q  <= CUTOFF_RST;
			notch_x_q <= NOTCH_X_RST;
			notch_y_q <= NOTCH_Y_RST;
			order_q   <= ORDER_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:    mode_q    <= cfg_wdata[0];
				REG_CUTOFF:  cutoff_q  <= cfg_wdata[CUTOFF_W-1:0];
				REG_NOTCH_X: notch_x_q <= cfg_wdata[NOTCH_W-1:0];
				REG_NOTCH_Y: notch_y_q <= cfg_wdata[NOTCH_W-1:0];
				REG_ORDER:   order_q   <= cfg_wdata[ORDER_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// derived config: cutoff squared and clamped order
	logic [W2_W-1:0] w2;
	logic [N_W-1:0]  n_eff;

	always_comb begin
		w2 = W2_W'(cutoff_q) * W2_W'(cutoff_q);
		if (order_q == '0) begin
			n_eff = N_W'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			n_eff = N_W'(MAX_ORDER);
		end else begin
			n_eff = N_W'(order_q);
		end
	end

	// notch offsets, low COORD_BITS bits taken as signed
	logic [EXT_W-1:0]             cx_ext, cy_ext;
	logic signed [COORD_BITS-1:0] cx, cy;

	assign cx_ext = {{COORD_BITS{1'b0}}, notch_x_q};
	assign cy_ext = {{COORD_BITS{1'b0}}, notch_y_q};
	assign cx     = cx_ext[COORD_BITS-1:0];
	assign cy     = cy_ext[COORD_BITS-1:0];

	// the pipeline never holds off a beat
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: distances to both notch centres
	logic                       vld_s1;
	logic signed [COORD_BITS:0] dua_s1, dva_s1, dub_s1, dvb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dua_s1 <= (COORD_BITS+1)'(u_coord) - (COORD_BITS+1)'(cx);
		dva_s1 <= (COORD_BITS+1)'(v_coord) - (COORD_BITS+1)'(cy);
		dub_s1 <= (COORD_BITS+1)'(u_coord) + (COORD_BITS+1)'(cx);
		dvb_s1 <= (COORD_BITS+1)'(v_coord) + (COORD_BITS+1)'(cy);
	end

	// two factor lanes; lane b only counts in notch mode
	logic                fa_vld, fb_vld, za, zb;
	logic [FACTOR_W-1:0] fa, fb;

	bnr_factor #(.COORD_BITS(COORD_BITS), .MAX_ORDER(MAX_ORDER), .N_W(N_W)) u_lane_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.w2       (w2),
		.n_eff    (n_eff),
		.in_valid (vld_s1),
		.du       (dua_s1),
		.dv       (dva_s1),
		.out_valid(fa_vld),
		.factor   (fa),
		.zero     (za)
	);

	bnr_factor #(.COORD_BITS(COORD_BITS), .MAX_ORDER(MAX_ORDER), .N_W(N_W)) u_lane_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.w2       (w2),
		.n_eff    (n_eff),
		.in_valid (vld_s1),
		.du       (dub_s1),
		.dv       (dvb_s1),
		.out_valid(fb_vld),
		.factor   (fb),
		.zero     (zb)
	);

	// final stage: combine factors, product kept in Q1.16
	logic [2*FACTOR_W-1:0] prod;
	logic                  done_q, at_centre_q;
	logic [FACTOR_W-1:0]   gain_q;

	assign prod = (2*FACTOR_W)'(fa) * (2*FACTOR_W)'(fb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fa_vld && (fb_vld || !mode_q);
		end
	end

	always_ff @(posedge clk) begin
		gain_q      <= mode_q ? prod[FACTOR_W+15:16] : fa;
		at_centre_q <= za || (mode_q && zb);
	end

	assign done      = done_q;
	assign gain      = gain_q;
	assign at_centre = at_centre_q;

endmodule

### hdl/bnr_checker.sv
// ----------------------------------------------------------------------------
// bnr_checker
// port-level checks of the mask block, bound to the top level
// ----------------------------------------------------------------------------
module bnr_checker
	import bnr_pkg::*;
#(
	parameter int MAX_ORDER = 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [FACTOR_W-1:0] gain,
	input logic                at_centre
);

	localparam int LATENCY = 52 + MAX_ORDER;

	// every accepted beat returns as a done beat once it has passed the whole pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing at fixed latency");

	// no result without a matching beat accepted before it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching beat");

	// a zero distance forces the whole gain to zero
	a_centre_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && at_centre) |-> (gain == '0))
		else $error("gain nonzero at notch centre");

	// gain never exceeds 1.0
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (gain <= FACTOR_W'(ONE_Q16)))
		else $error("gain above unity");

endmodule

bind butterworth_notch_reject_mask bnr_checker #(.MAX_ORDER(MAX_ORDER)) u_bnr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.gain     (gain),
	.at_centre(at_centre)
);

### verif/tb_butterworth_notch_reject_mask.sv
// ----------------------------------------------------------------------------
// tb_butterworth_notch_reject_mask
// self-checking bench for the butterworth notch-reject mask: coordinate beats
// go in through the command port, every done beat is checked against a
// fixed-point predictor of the gain, under several register settings
// ----------------------------------------------------------------------------
module tb_butterworth_notch_reject_mask;
	timeunit 1ns;
	timeprecision 1ps;
	import bnr_pkg::*;

	localparam int CB       = 11;
	localparam int MAXO     = 8;
	localparam int LATENCY  = 52 + MAXO;
	localparam int WD_LIMIT = 20000;
	localparam int N_RANDOM = 700;

	// indexes with no register behind them
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_A = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_B = 3'd7;

	typedef struct {
		logic [FACTOR_W-1:0] gain;
		logic                at_centre;
	} mask_t;

	// scoreboard: predicts the mask value per coordinate and holds the
	// expected beats in order
	class mask_scoreboard;
		logic                mode;
		logic [CUTOFF_W-1:0] cutoff;
		logic [NOTCH_W-1:0]  notch_x;
		logic [NOTCH_W-1:0]  notch_y;
		logic [ORDER_W-1:0]  order;
		mask_t               pending[$];
		int                  errors;

		function new();
			mode    = 1'b1;
			cutoff  = CUTOFF_RST;
			notch_x = NOTCH_X_RST;
			notch_y = NOTCH_Y_RST;
			order   = ORDER_RST;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MODE:    mode    = val[0];
				REG_CUTOFF:  cutoff  = val;
				REG_NOTCH_X: notch_x = val[NOTCH_W-1:0];
				REG_NOTCH_Y: notch_y = val[NOTCH_W-1:0];
				REG_ORDER:   order   = val[ORDER_W-1:0];
				default: ;
			endcase
		endfunction

		// one high-pass factor 1/(1+t^n) in Q1.16
		function longint unsigned hp_gain(longint du, longint dv, ref logic zero);
			longint unsigned d2, t, p, w, n;
			d2 = du * du + dv * dv;
			if (d2 == 0) begin
				zero = 1'b1;
				return 0;
			end
			n = order;
			if (n == 0) n = 1;
			if (n > MAXO) n = MAXO;
			w = cutoff;
			t = (w * w) / d2;
			p = t;
			for (longint unsigned i = 1; i < n; i++) begin
				p = (p * t) >> 16;
				if (p >= 64'hFFFF_FFFF) begin
					p = 64'hFFFF_FFFF;
					break;
				end
			end
			return (64'd1 << 32) / (64'd65536 + p);
		endfunction

		function void note_coord(logic signed [CB-1:0] u, logic signed [CB-1:0] v);
			longint su, sv, cx, cy;
			longint unsigned g;
			logic zero;
			mask_t m;
			su = u;
			sv = v;
			cx = $signed(notch_x);
			cy = $signed(notch_y);
			zero = 1'b0;
			g = hp_gain(su - cx, sv - cy, zero);
			if (mode)
				g = (g * hp_gain(su + cx, sv + cy, zero)) >> 16;
			m.gain = g[FACTOR_W-1:0];
			m.at_centre = zero;
			pending.push_back(m);
		endfunction

		function void check_mask(logic [FACTOR_W-1:0] g, logic c);
			mask_t m;
			if (pending.size() == 0) begin
				$error("unexpected done beat: gain %0d at_centre %0d", g, c);
				errors++;
				return;
			end
			m = pending.pop_front();
			if (g !== m.gain) begin
				$error("gain: expected %0d, actual %0d", m.gain, g);
				errors++;
			end
			if (c !== m.at_centre) begin
				$error("at_centre: expected %0d, actual %0d", m.at_centre, c);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic signed [CB-1:0]  u_coord = '0;
	logic signed [CB-1:0]  v_coord = '0;
	logic                  done;
	logic [FACTOR_W-1:0]   gain;
	logic                  at_centre;

	mask_scoreboard sb = new();
	int idle_cycles = 0;

	always #5 clk = ~clk;

	butterworth_notch_reject_mask #(.COORD_BITS(CB), .MAX_ORDER(MAXO)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .u_coord(u_coord), .v_coord(v_coord),
		.done(done), .gain(gain), .at_centre(at_centre)
	);

	// monitor: note inputs and check results at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_coord(u_coord, v_coord);
			if (done) sb.check_mask(gain, at_centre);
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	// watchdog on cycles without any accepted beat or result
	always @(posedge clk) begin
		if (idle_cycles >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// register write while idle; cfg_we is dropped again and the bus left quiet before the task returns
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_all(logic m, logic [15:0] w, logic [10:0] x, logic [10:0] y,
			logic [3:0] n);
		write_reg(REG_MODE, {15'd0, m});
		write_reg(REG_CUTOFF, w);
		write_reg(REG_NOTCH_X, {5'd0, x});
		write_reg(REG_NOTCH_Y, {5'd0, y});
		write_reg(REG_ORDER, {12'd0, n});
	endtask

	// one coordinate beat; start stays high across back-to-back beats
	task automatic send_coord(logic signed [CB-1:0] u, logic signed [CB-1:0] v);
		start   <= 1'b1;
		u_coord <= u;
		v_coord <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic gap(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// stop sending and let every expected beat come back
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// coordinates biased toward the notch centers, where the gain moves
	function automatic logic signed [CB-1:0] near(logic [10:0] c, bit neg);
		int off;
		case ($urandom_range(0, 3))
			0: return CB'($urandom);
			default: begin
				off = $signed($urandom_range(0, 40)) - 20;
				return CB'((neg ? -$signed(c) : $signed(c)) + off);
			end
		endcase
	endfunction

	task automatic random_phase(int count);
		int sent;
		bit neg;
		sent = 0;
		while (sent < count) begin
			// burst of random length, sometimes long without gaps
			repeat ($urandom_range(1, 30)) begin
				neg = 1'($urandom_range(0, 1));
				send_coord(near(sb.notch_x, neg), near(sb.notch_y, neg));
				sent++;
			end
			if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 8));
		end
		drain();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, centers, extremes
		send_coord(11'sd32, 11'sd16);
		send_coord(-11'sd32, -11'sd16);
		send_coord(11'sd0, 11'sd0);
		send_coord(-11'sd1024, -11'sd1024);
		send_coord(11'sd1023, 11'sd1023);
		send_coord(-11'sd1024, 11'sd1023);
		send_coord(11'sd33, 11'sd16);
		drain();

		// zero cutoff, both at and away from the center
		set_all(1'b0, 16'd0, 11'd0, 11'd0, 4'd3);
		send_coord(11'sd0, 11'sd0);
		send_coord(11'sd1, 11'sd0);
		send_coord(-11'sd1024, 11'sd5);
		drain();

		// huge cutoff and order at max, order zero, order above max
		set_all(1'b1, 16'hFFFF, 11'h400, 11'h3FF, 4'd8);
		send_coord(11'sd1, 11'sd1);
		send_coord(-11'sd1024, 11'sd1023);
		send_coord(11'sd1023, -11'sd1023);
		send_coord(11'sd0, 11'sd0);
		drain();
		write_reg(REG_ORDER, 16'd0);
		write_reg(REG_CUTOFF, 16'h0100);
		send_coord(11'sd2, 11'sd0);
		send_coord(11'sd0, 11'sd1);
		drain();
		write_reg(REG_ORDER, 16'hFFFF);
		send_coord(11'sd1, 11'sd0);
		send_coord(11'sd3, 11'sd4);
		drain();
		// unknown register index is ignored
		write_reg(REG_UNMAPPED_B, 16'hFFFF);
		write_reg(REG_UNMAPPED_A, 16'h0000);
		send_coord(11'sd7, -11'sd9);
		drain();

		// random phases over several settings
		set_all(1'b1, 16'd512, 11'd32, 11'd16, 4'd1);
		random_phase(N_RANDOM / 7);
		set_all(1'b0, 16'h0A00, 11'h7F0, 11'd100, 4'd2);
		random_phase(N_RANDOM / 7);
		set_all(1'b1, 16'h2000, 11'd300, 11'h700, 4'd4);
		random_phase(N_RANDOM / 7);
		repeat (4) begin
			set_all(1'($urandom), 16'($urandom), 11'($urandom), 11'($urandom),
				4'($urandom_range(0, 15)));
			random_phase(N_RANDOM / 7);
		end

		// wait out the pipeline and decide
		start <= 1'b0;
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (sb.pending.size() != 0)
				$error("%0d expected beats never arrived", sb.pending.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

### sim.f
hdl/bnr_pkg.sv
hdl/bnr_udiv.sv
hdl/bnr_power.sv
hdl/bnr_factor.sv
hdl/butterworth_notch_reject_mask.sv
hdl/bnr_checker.sv
verif/tb_butterworth_notch_reject_mask.sv
